@@ src/pcan_pkg.sv @@
// ----------------------------------------------------------------------------
// pcan_pkg
// Shared types and character constants for the path canonicaliser.
// ----------------------------------------------------------------------------
package pcan_pkg;

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  typedef enum logic [2:0] {
    ST_IDLE,   // taking characters
    ST_SUM,    // walking the stack to size the result
    ST_ROOT,   // leading '/'
    ST_CRD,    // component entry read issued
    ST_CWAIT,  // component entry returned
    ST_CHR,    // streaming component characters
    ST_DRAIN   // last character read in flight
  } pcan_state_t;

  // one output character handed to the word packer
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_push_t;

endpackage

@@ src/path_canonicalizer.sv @@
// ----------------------------------------------------------------------------
// path_canonicalizer
// Streaming path normaliser: drops empty and "." components, resolves "..".
// ----------------------------------------------------------------------------
// A character item is taken without raising busy, so characters may be
// issued back to back. The terminator raises busy while the block walks the
// component stack twice: once to size the result over the stack memory's
// read port, then to emit the leading '/', then for each component a stack
// entry read (the separator goes out as the entry returns) followed by its
// characters, and finally a drain of the last raw store read.
// Result words appear on result_strobe for a single cycle and cannot be held
// off; truncated is known before the first word and holds on every word.
// ----------------------------------------------------------------------------
module path_canonicalizer #(
  parameter int PATH_BYTES  = 256,
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  ch,
  input  logic        end_req,
  output logic        result_strobe,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last_word,
  output logic        truncated
);

  localparam int AW = $clog2(PATH_BYTES);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [AW-1:0] CAP    = AW'(PATH_BYTES - 1);
  localparam logic [DW-1:0] SD_MAX = DW'(STACK_DEPTH);
  localparam logic [AW+1:0] SAT    = (AW+2)'(PATH_BYTES);

  // storage
  logic [7:0]      raw_mem  [PATH_BYTES];
  logic [2*AW-1:0] comp_mem [STACK_DEPTH];
  logic [7:0]      raw_q;
  logic [2*AW-1:0] comp_q;

  // path-building state
  pcan_pkg::pcan_state_t state, state_next;
  logic [AW-1:0] pos;
  logic [AW-1:0] cur_start;
  logic [AW-1:0] cur_len;
  logic [7:0]    c0, c1;
  logic [DW-1:0] depth;
  logic          ovf;

  // result walk state
  logic [DW-1:0] e_depth;
  logic          e_ovf;
  logic [DW-1:0] idx;
  logic          sum_v;
  logic [AW:0]   acc;
  logic [AW-1:0] out_len;
  logic          trunc;
  logic [DW-1:0] ci;
  logic [AW-1:0] rptr;
  logic [AW-1:0] remain;
  logic          raw_pend;

  // decode
  logic          acc_in, char_in, term_in, char_store, is_slash;
  logic          close_en, is_dot, is_dd, plain;
  logic          do_push, do_pop, push_ovf;
  logic [DW-1:0] depth_close;
  logic [AW+1:0] sum_add;
  logic [AW:0]   acc_sat;
  logic [IW-1:0] comp_addr;

  // sequencer strobes
  logic sum_issue, finish_sum, root_push, slash_push, load_comp, chr_issue;
  pcan_pkg::byte_push_t push;
  logic final_push;

  assign busy = (state != pcan_pkg::ST_IDLE);

  always_comb begin
    acc_in      = start && !busy;
    char_in     = acc_in && !end_req;
    term_in     = acc_in && end_req;
    char_store  = char_in && (pos < CAP);
    is_slash    = (ch == pcan_pkg::SLASH);
    close_en    = (char_store && is_slash) || term_in;
    is_dot      = (cur_len == AW'(1)) && (c0 == pcan_pkg::DOT);
    is_dd       = (cur_len == AW'(2)) && (c0 == pcan_pkg::DOT) && (c1 == pcan_pkg::DOT);
    plain       = (cur_len != '0) && !is_dot && !is_dd;
    do_pop      = close_en && is_dd && (depth != '0);
    do_push     = close_en && plain && (depth < SD_MAX);
    push_ovf    = close_en && plain && (depth == SD_MAX);
    depth_close = do_push ? depth + DW'(1) : (do_pop ? depth - DW'(1) : depth);

    // each component costs its length plus one separator; saturate past the cap
    sum_add = {1'b0, acc} + (AW+2)'(comp_q[AW-1:0]) + (AW+2)'(1);
    acc_sat = (sum_add >= SAT) ? (AW+1)'(PATH_BYTES) : sum_add[AW:0];

    comp_addr = (state == pcan_pkg::ST_SUM) ? idx[IW-1:0] : ci[IW-1:0];
  end

  // FSM next state and strobes
  always_comb begin
    state_next = state;
    sum_issue  = 1'b0;
    finish_sum = 1'b0;
    root_push  = 1'b0;
    slash_push = 1'b0;
    load_comp  = 1'b0;
    chr_issue  = 1'b0;
    unique case (state)
      pcan_pkg::ST_IDLE: begin
        if (term_in) state_next = pcan_pkg::ST_SUM;
      end
      pcan_pkg::ST_SUM: begin
        if (idx != e_depth) begin
          sum_issue = 1'b1;
        end else if (!sum_v) begin
          finish_sum = 1'b1;
          state_next = pcan_pkg::ST_ROOT;
        end
      end
      pcan_pkg::ST_ROOT: begin
        root_push  = 1'b1;
        state_next = pcan_pkg::ST_CRD;
      end
      pcan_pkg::ST_CRD: begin
        state_next = pcan_pkg::ST_CWAIT;
      end
      pcan_pkg::ST_CWAIT: begin
        load_comp  = 1'b1;
        slash_push = (ci != '0);
        state_next = pcan_pkg::ST_CHR;
      end
      pcan_pkg::ST_CHR: begin
        chr_issue = 1'b1;
        if (remain == AW'(1)) begin
          state_next = ((ci + DW'(1)) < e_depth) ? pcan_pkg::ST_CRD : pcan_pkg::ST_DRAIN;
        end
      end
      pcan_pkg::ST_DRAIN: begin
        state_next = pcan_pkg::ST_DRAIN;
      end
      default: state_next = pcan_pkg::ST_IDLE;
    endcase
    // the walk always ends on the final character transfer
    if (final_push) state_next = pcan_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pcan_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // path-building registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      cur_start <= '0;
      cur_len   <= '0;
      depth     <= '0;
      ovf       <= 1'b0;
    end else if (term_in) begin
      pos       <= '0;
      cur_start <= '0;
      cur_len   <= '0;
      depth     <= '0;
      ovf       <= 1'b0;
    end else if (char_in) begin
      if (!char_store) begin
        ovf <= 1'b1;
      end else begin
        pos <= pos + AW'(1);
        if (is_slash) begin
          depth     <= depth_close;
          cur_start <= pos + AW'(1);
          cur_len   <= '0;
          if (push_ovf) ovf <= 1'b1;
        end else begin
          cur_len <= cur_len + AW'(1);
        end
      end
    end
  end

  // first two characters of the open component, for the dot checks
  always_ff @(posedge clk) begin
    if (char_store && !is_slash) begin
      if (cur_len == '0)     c0 <= ch;
      if (cur_len == AW'(1)) c1 <= ch;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (char_store) raw_mem[pos] <= ch;
    if (do_push)    comp_mem[depth[IW-1:0]] <= {cur_start, cur_len};
    raw_q  <= raw_mem[rptr];
    comp_q <= comp_mem[comp_addr];
  end

  // result walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_v    <= 1'b0;
      raw_pend <= 1'b0;
      idx      <= '0;
      ci       <= '0;
      e_depth  <= '0;
    end else begin
      sum_v    <= sum_issue;
      raw_pend <= chr_issue;
      if (term_in) begin
        e_depth <= depth_close;
        idx     <= '0;
        ci      <= '0;
      end else begin
        if (sum_issue) idx <= idx + DW'(1);
        if (chr_issue && remain == AW'(1)) ci <= ci + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term_in) begin
      e_ovf <= ovf || push_ovf;
      acc   <= '0;
    end else if (sum_v) begin
      acc <= acc_sat;
    end
    if (finish_sum) begin
      if (acc == '0)           out_len <= AW'(1);
      else if (acc > {1'b0, CAP}) out_len <= CAP;
      else                     out_len <= acc[AW-1:0];
      trunc <= e_ovf || (acc > {1'b0, CAP});
    end
    if (load_comp) begin
      rptr   <= comp_q[2*AW-1:AW];
      remain <= comp_q[AW-1:0];
    end else if (chr_issue) begin
      rptr   <= rptr + AW'(1);
      remain <= remain - AW'(1);
    end
  end

  always_comb begin
    push.vld  = busy && (root_push || slash_push || raw_pend);
    push.data = raw_pend ? raw_q : pcan_pkg::SLASH;
  end

  pcan_pack #(
    .LEN_W(AW)
  ) u_pack (
    .clk          (clk),
    .rst          (rst),
    .clear        (finish_sum),
    .push         (push),
    .out_len      (out_len),
    .trunc        (trunc),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .truncated    (truncated),
    .result_strobe(result_strobe),
    .final_push   (final_push)
  );

  // checks
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_word |-> state == pcan_pkg::ST_IDLE)
    else $error("last word without return to idle");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_word |-> busy)
    else $error("intermediate word after walk ended");

  a_chr_remain: assert property (@(posedge clk) disable iff (rst)
    state == pcan_pkg::ST_CHR |-> remain != '0)
    else $error("character walk past component end");

  a_term_busy: assert property (@(posedge clk) disable iff (rst)
    term_in |=> busy && depth == '0)
    else $error("terminator did not start the result walk");

endmodule

@@ src/pcan_pack.sv @@
// ----------------------------------------------------------------------------
// pcan_pack
// Packs the output character stream into 8-byte result words.
// ----------------------------------------------------------------------------
module pcan_pack #(
  parameter int LEN_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  pcan_pkg::byte_push_t push,
  input  logic [LEN_W-1:0]    out_len,
  input  logic                trunc,
  output logic [63:0]         out_bytes,
  output logic [3:0]          byte_count,
  output logic                last_word,
  output logic                truncated,
  output logic                result_strobe,
  output logic                final_push
);

  logic [63:0]      wbuf;
  logic [2:0]       wcnt;
  logic [LEN_W-1:0] ecnt;

  logic [63:0]      wbuf_next;
  logic [3:0]       cnt_next;
  logic [LEN_W-1:0] ecnt_next;
  logic             fin;
  logic             flush;

  always_comb begin
    // slots beyond wcnt are always zero, so OR-ing in is enough
    wbuf_next  = wbuf | ({56'b0, push.data} << {wcnt, 3'b000});
    cnt_next   = {1'b0, wcnt} + 4'd1;
    ecnt_next  = ecnt + LEN_W'(1);
    fin        = (ecnt_next == out_len);
    flush      = (cnt_next == 4'd8) || fin;
    final_push = push.vld && fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wbuf          <= '0;
      wcnt          <= '0;
      ecnt          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (clear) begin
        wbuf <= '0;
        wcnt <= '0;
        ecnt <= '0;
      end else if (push.vld) begin
        ecnt <= ecnt_next;
        if (flush) begin
          wbuf          <= '0;
          wcnt          <= '0;
          result_strobe <= 1'b1;
        end else begin
          wbuf <= wbuf_next;
          wcnt <= cnt_next[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld && flush && !clear) begin
      out_bytes  <= wbuf_next;
      byte_count <= cnt_next;
      last_word  <= fin;
      truncated  <= trunc;
    end
  end

endmodule

@@ verif/tb_path_canonicalizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_canonicalizer
// Self-checking bench for the path canonicaliser. Raw paths go in one
// character per transfer, with bursty start and random gaps. A local path
// model predicts every result word. A checker compares each strobed word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_path_canonicalizer;

  localparam int PATH_BYTES  = 256;
  localparam int STACK_DEPTH = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 410;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        trunc;
  } path_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  ch = 8'h00;
  logic        end_req = 1'b0;
  logic        result_strobe;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        truncated;

  int unsigned cycle_count = 0;
  int          errors = 0;
  int          burst_left = 0;

  // path model state
  logic [7:0]  raw_chars [PATH_BYTES];
  int          stk_start [STACK_DEPTH];
  int          stk_len   [STACK_DEPTH];
  int          stk_depth = 0;
  int          wr_pos = 0;
  int          seg_start = 0;
  int          seg_len = 0;
  logic        dropped = 1'b0;
  path_word_t  expected_words [$];

  path_canonicalizer #(
    .PATH_BYTES (PATH_BYTES),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .ch           (ch),
    .end_req      (end_req),
    .result_strobe(result_strobe),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .truncated    (truncated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("path_canonicalizer: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic void close_segment();
    if (seg_len == 0)
      return;
    if (seg_len == 1 && raw_chars[seg_start] == pcan_pkg::DOT)
      return;
    if (seg_len == 2 && raw_chars[seg_start] == pcan_pkg::DOT &&
        raw_chars[seg_start + 1] == pcan_pkg::DOT) begin
      if (stk_depth > 0)
        stk_depth--;
      return;
    end
    if (stk_depth < STACK_DEPTH) begin
      stk_start[stk_depth] = seg_start;
      stk_len[stk_depth]   = seg_len;
      stk_depth++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // advance the path model by one accepted transfer; a terminator queues the words
  function automatic void canonicalise_step(input logic [7:0] c, input logic term);
    logic [7:0] line_buf [$];
    logic       clip;
    path_word_t word;
    int         n;
    clip = 1'b0;
    if (!term) begin
      if (wr_pos >= PATH_BYTES - 1) begin
        dropped = 1'b1;
        return;
      end
      raw_chars[wr_pos] = c;
      wr_pos++;
      if (c == pcan_pkg::SLASH) begin
        close_segment();
        seg_start = wr_pos;
        seg_len   = 0;
      end else begin
        seg_len++;
      end
      return;
    end
    close_segment();
    line_buf.push_back(pcan_pkg::SLASH);
    for (int i = 0; i < stk_depth; i++) begin
      if (i > 0) begin
        if (line_buf.size() < PATH_BYTES - 1) line_buf.push_back(pcan_pkg::SLASH);
        else clip = 1'b1;
      end
      for (int j = 0; j < stk_len[i]; j++) begin
        if (line_buf.size() < PATH_BYTES - 1) line_buf.push_back(raw_chars[stk_start[i] + j]);
        else clip = 1'b1;
      end
    end
    for (int base = 0; base < line_buf.size(); base += 8) begin
      n = line_buf.size() - base;
      if (n > 8)
        n = 8;
      word.data = '0;
      for (int k = 0; k < n; k++)
        word.data[8*k +: 8] = line_buf[base + k];
      word.cnt   = 4'(n);
      word.last  = (base + 8 >= line_buf.size());
      word.trunc = dropped | clip;
      expected_words.push_back(word);
    end
    stk_depth = 0;
    wr_pos    = 0;
    seg_start = 0;
    seg_len   = 0;
    dropped   = 1'b0;
  endfunction

  // one transfer; bursts of random length separated by random gaps
  task automatic send_item(input logic [7:0] c, input logic term);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap > 0) begin
        start   <= 1'b0;
        ch      <= 8'($urandom_range(0, 255));
        end_req <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
    start   <= 1'b1;
    ch      <= c;
    end_req <= term;
    do @(posedge clk); while (busy);
    canonicalise_step(c, term);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 7) == 0)
      return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0)
      return pcan_pkg::DOT;
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  always @(posedge clk) begin : check_results
    path_word_t want;
    if (!rst && result_strobe) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = expected_words.pop_front();
        if (out_bytes !== want.data)
          report_mismatch($sformatf("out_bytes %h, want %h", out_bytes, want.data));
        if (byte_count !== want.cnt)
          report_mismatch($sformatf("byte_count %0d, want %0d", byte_count, want.cnt));
        if (last_word !== want.last)
          report_mismatch($sformatf("last_word %b, want %b", last_word, want.last));
        if (truncated !== want.trunc)
          report_mismatch($sformatf("truncated %b, want %b", truncated, want.trunc));
      end
    end
  end

  // empty path, skip/pop/push rules, pop at root, byte extremes
  task automatic test_rules();
    send_item(8'hFF, 1'b1);
    send_text("/./../");
    send_item(8'h00, 1'b1);
    send_text("/a/./../.../");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);
  endtask

  // characters past the store limit are dropped, slashes included
  task automatic test_input_overflow();
    for (int i = 0; i < 270; i++)
      send_item((i % 9 == 8) ? pcan_pkg::SLASH : 8'(8'h61 + i % 26), 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // pushes onto a full stack are lost; a pop then frees a slot
  task automatic test_stack_full();
    for (int i = 0; i < STACK_DEPTH + 4; i++)
      send_text($sformatf("/c%0d", i));
    send_text("/../tail");
    send_item(8'h00, 1'b1);
  endtask

  // longest unclipped output, then one character too many
  task automatic test_output_clip();
    repeat (PATH_BYTES - 2) send_item(8'h7A, 1'b0);
    send_item(8'h00, 1'b1);
    repeat (PATH_BYTES - 1) send_item(8'h7A, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // mostly well-formed paths with random content, some raw noise
  task automatic test_random();
    logic [7:0] chars [$];
    int         items;
    int         n_comp;
    int         len;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      chars.delete();
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 24);
        repeat (len) chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) != 0)
          chars.push_back(pcan_pkg::SLASH);
        n_comp = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n_comp; i++) begin
          if (i > 0)
            chars.push_back(pcan_pkg::SLASH);
          case ($urandom_range(0, 9))
            0: ;
            1: chars.push_back(pcan_pkg::DOT);
            2, 3: begin
              chars.push_back(pcan_pkg::DOT);
              chars.push_back(pcan_pkg::DOT);
            end
            default: begin
              len = $urandom_range(1, 6);
              repeat (len) chars.push_back(name_char());
            end
          endcase
        end
        if ($urandom_range(0, 4) == 0)
          chars.push_back(pcan_pkg::SLASH);
      end
      foreach (chars[i])
        send_item(chars[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      items += chars.size() + 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_rules();
    test_input_overflow();
    test_stack_full();
    test_output_clip();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    foreach (expected_words[i])
      report_mismatch("result word never arrived");
    if (errors == 0)
      $display("path_canonicalizer: match");
    else
      $display("path_canonicalizer: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
src/pcan_pkg.sv
src/pcan_pack.sv
src/path_canonicalizer.sv
verif/tb_path_canonicalizer.sv
